// ===== rtl/core/miller_rabin_witness_check_defines.svh =====
// assertion macros for the witness check block
`ifndef MILLER_RABIN_WITNESS_CHECK_DEFINES_SVH
`define MILLER_RABIN_WITNESS_CHECK_DEFINES_SVH
`ifndef SYNTHESIS
`define MRW_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define MRW_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MRW_ASSERT(label, clk, rst_n, prop)
`define MRW_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== rtl/core/mrw_pkg.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// mrw_pkg
// shared types for the witness check controller and datapath
// ------------------------------------------------------------------------
package mrw_pkg;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_HALVE,
		OP_MUL_RB,
		OP_MUL_BB,
		OP_MUL_XX,
		OP_SHIFT_E,
		OP_COPY
	} op_t;

	typedef struct packed {
		op_t  op;
		logic start;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic e_zero;
		logic e_lsb;
		logic u_odd;
		logic t_zero;
		logic x_one;
		logic x_nm1;
		logic small_n;
	} sts_t;

endpackage

// ===== rtl/core/mrw_stream_if.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// mrw_stream_if
// valid/ready channel with a generic payload
// ------------------------------------------------------------------------
interface mrw_stream_if #(
	parameter int W = 1
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mrw_datapath.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// mrw_datapath
// operand registers and a shared shift-and-add modular multiplier
// ------------------------------------------------------------------------
module mrw_datapath #(
	parameter int WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mrw_pkg::cmd_t     cmd,
	input  logic [WIDTH-1:0]  ld_n,
	input  logic [WIDTH-1:0]  ld_a,
	output mrw_pkg::sts_t     sts
);
	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] n_q, u_q, e_q, r_q, b_q, x_q;
	logic [WIDTH-1:0] acc_q, mx_q, my_q;
	logic [CW-1:0]    cnt_q, t_q;
	logic             busy_q, done_q;
	mrw_pkg::op_t     op_q;

	logic [WIDTH:0]   dbl, dbl_r, add, add_r;
	logic [WIDTH-1:0] step1, step2;

	// modular double then conditional add
	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = dbl - {1'b0, n_q};
		step1 = (dbl >= {1'b0, n_q}) ? dbl_r[WIDTH-1:0] : acc_q << 1;
		add   = {1'b0, step1} + {1'b0, mx_q};
		add_r = add - {1'b0, n_q};
		if (my_q[WIDTH-1])
			step2 = (add >= {1'b0, n_q}) ? add_r[WIDTH-1:0] : add[WIDTH-1:0];
		else
			step2 = step1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= mrw_pkg::OP_NONE;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				unique case (cmd.op)
					mrw_pkg::OP_LOAD: begin
						n_q    <= ld_n;
						u_q    <= ld_n - WIDTH'(1);
						e_q    <= ld_n - WIDTH'(1);
						t_q    <= '0;
						// base reduced as (1 * a) mod n
						mx_q   <= WIDTH'(1);
						my_q   <= ld_a;
						acc_q  <= '0;
						cnt_q  <= CW'(WIDTH);
						busy_q <= 1'b1;
						op_q   <= mrw_pkg::OP_LOAD;
					end
					mrw_pkg::OP_HALVE: begin
						u_q <= u_q >> 1;
						e_q <= u_q >> 1;
						t_q <= t_q + CW'(1);
					end
					mrw_pkg::OP_SHIFT_E: e_q <= e_q >> 1;
					mrw_pkg::OP_COPY:    x_q <= r_q;
					mrw_pkg::OP_MUL_RB: begin
						mx_q <= r_q; my_q <= b_q; acc_q <= '0;
						cnt_q <= CW'(WIDTH); busy_q <= 1'b1; op_q <= cmd.op;
					end
					mrw_pkg::OP_MUL_BB: begin
						mx_q <= b_q; my_q <= b_q; acc_q <= '0;
						cnt_q <= CW'(WIDTH); busy_q <= 1'b1; op_q <= cmd.op;
					end
					mrw_pkg::OP_MUL_XX: begin
						mx_q <= x_q; my_q <= x_q; acc_q <= '0;
						cnt_q <= CW'(WIDTH); busy_q <= 1'b1; op_q <= cmd.op;
					end
					default: ;
				endcase
			end else if (busy_q) begin
				acc_q <= step2;
				my_q  <= my_q << 1;
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					unique case (op_q)
						mrw_pkg::OP_LOAD: begin
							b_q <= step2;
							r_q <= WIDTH'(1);
						end
						mrw_pkg::OP_MUL_RB: r_q <= step2;
						mrw_pkg::OP_MUL_BB: b_q <= step2;
						mrw_pkg::OP_MUL_XX: begin
							x_q <= step2;
							t_q <= t_q - CW'(1);
						end
						default: ;
					endcase
				end
			end
		end
	end

	assign sts.busy    = busy_q;
	assign sts.done    = done_q;
	assign sts.e_zero  = (e_q == '0);
	assign sts.e_lsb   = e_q[0];
	assign sts.u_odd   = u_q[0];
	assign sts.t_zero  = (t_q == '0);
	assign sts.x_one   = (x_q == WIDTH'(1));
	assign sts.x_nm1   = (x_q == n_q - WIDTH'(1));
	assign sts.small_n = (n_q < WIDTH'(3));
endmodule

// ===== rtl/core/mrw_ctrl.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// mrw_ctrl
// sequencer for one witness round over the shared multiplier
// ------------------------------------------------------------------------
module mrw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          composite,
	output logic          invalid,
	output mrw_pkg::cmd_t cmd,
	input  mrw_pkg::sts_t sts
);
	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_CHECK, S_HALVE, S_POW, S_MRB, S_MBB, S_SHE,
		S_SQ, S_SQW, S_OUT
	} state_t;

	state_t state_q;
	logic   comp_q, inv_q, ovalid_q, wcomp_q, winv_q, xprev_one_q, xprev_nm1_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;
	assign composite = comp_q;
	assign invalid   = inv_q;

	always_comb begin
		cmd.start = 1'b0;
		cmd.op    = mrw_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE:  if (in_valid) begin cmd.start = 1'b1; cmd.op = mrw_pkg::OP_LOAD; end
			S_HALVE: if (!sts.u_odd) begin cmd.start = 1'b1; cmd.op = mrw_pkg::OP_HALVE; end
			S_SHE:   begin cmd.start = 1'b1; cmd.op = mrw_pkg::OP_SHIFT_E; end
			S_POW: begin
				cmd.start = 1'b1;
				if (sts.e_zero)
					cmd.op = mrw_pkg::OP_COPY;
				else
					cmd.op = sts.e_lsb ? mrw_pkg::OP_MUL_RB : mrw_pkg::OP_MUL_BB;
			end
			S_MRB:   if (sts.done) begin cmd.start = 1'b1; cmd.op = mrw_pkg::OP_MUL_BB; end
			S_SQ:    if (!sts.t_zero) begin cmd.start = 1'b1; cmd.op = mrw_pkg::OP_MUL_XX; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			comp_q      <= 1'b0;
			inv_q       <= 1'b0;
			ovalid_q    <= 1'b0;
			wcomp_q     <= 1'b0;
			winv_q      <= 1'b0;
			xprev_one_q <= 1'b0;
			xprev_nm1_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!ovalid_q || out_ready))
				ovalid_q <= 1'b1;
			else if (ovalid_q && out_ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_LOAD;
				S_LOAD:  if (sts.done) state_q <= S_CHECK;
				S_CHECK: begin
					wcomp_q <= 1'b0;
					if (sts.small_n) begin
						winv_q <= 1'b1; state_q <= S_OUT;
					end else begin
						winv_q <= 1'b0; state_q <= S_HALVE;
					end
				end
				// strip factors of two from n-1, counting t
				S_HALVE: if (sts.u_odd) state_q <= S_POW;
				S_POW: begin
					if (sts.e_zero) state_q <= S_SQ;
					else state_q <= sts.e_lsb ? S_MRB : S_MBB;
				end
				S_MRB:   if (sts.done) state_q <= S_MBB;
				S_MBB:   if (sts.done) state_q <= S_SHE;
				S_SHE:   state_q <= S_POW;
				S_SQ: begin
					if (sts.t_zero) begin
						wcomp_q <= !sts.x_one;
						state_q <= S_OUT;
					end else begin
						xprev_one_q <= sts.x_one;
						xprev_nm1_q <= sts.x_nm1;
						state_q     <= S_SQW;
					end
				end
				S_SQW: if (sts.done) begin
					// nontrivial square root of one
					if (sts.x_one && !xprev_one_q && !xprev_nm1_q) begin
						wcomp_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_OUT: if (!ovalid_q || out_ready) begin
					comp_q  <= wcomp_q;
					inv_q   <= winv_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/miller_rabin_witness_check.sv =====
`timescale 1ns / 1ps
// throughput: one item at a time; the shared shift-and-add multiplier sets the rate
// reset: arst_n clears the controller and multiplier control; payload registers are not reset
// ------------------------------------------------------------------------
// miller_rabin_witness_check
// one miller-rabin witness round over a shared modular multiplier
// ------------------------------------------------------------------------
`include "miller_rabin_witness_check_defines.svh"
module miller_rabin_witness_check #(
	parameter int WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mrw_stream_if.sink           in_ch,
	mrw_stream_if.source         out_ch
);
	mrw_pkg::cmd_t cmd;
	mrw_pkg::sts_t sts;
	logic comp, inv;

	mrw_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.ld_n(in_ch.data[WIDTH-1:0]), .ld_a(in_ch.data[64+WIDTH-1:64]), .sts(sts)
	);

	mrw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.composite(comp), .invalid(inv), .cmd(cmd), .sts(sts)
	);

	assign out_ch.data = {inv, comp};

	`MRW_ASSERT(a_inv_not_comp, clk, arst_n, out_ch.valid |-> !(out_ch.data[1] && out_ch.data[0]))
	`MRW_ASSERT(a_no_accept_busy, clk, arst_n, sts.busy |-> !in_ch.ready)
endmodule
